FILE: sv/assert_macros.svh
// Assertion macros used by the counting sort datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/csort_pkg.sv
// Shared types, constants and helpers for the counting sort block.
`default_nettype none

package csort_pkg;

    localparam int KEY_BITS  = 10;
    localparam int KEY_RANGE = 1 << KEY_BITS;

    typedef logic [KEY_BITS-1:0] t_slot;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] sorted_key;
        logic                       last_res;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take input requests
        logic start;      // set up pointers for the sort passes
        logic pf_run;     // prefix-sum pass
        logic pl_run;     // placement pass
        logic clr_run;    // histogram clearing sweep
        logic out_run;    // emit sorted keys
        logic set_clear;  // drop count and min/max for the next set
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic pf_done;
        logic pl_done;
        logic out_done;
    } t_sts;

    // Histogram slot: key offset by half the range, i.e. MSB inverted.
    function automatic t_slot slot_of(input logic [KEY_BITS-1:0] k);
        return {~k[KEY_BITS-1], k[KEY_BITS-2:0]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/csort_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module csort_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/csort_ctrl.sv
// Phase sequencer for the counting sort: load, prefix, place, clear, output.
`default_nettype none

module csort_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire csort_pkg::t_sts   i_sts,
    output csort_pkg::t_cmd        o_cmd
);

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_LOAD   = 7'b0000010,
        ST_START  = 7'b0000100,
        ST_PREFIX = 7'b0001000,
        ST_PLACE  = 7'b0010000,
        ST_CLEAR  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_last) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_in_valid && i_in_last) n_state = ST_START;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_PREFIX;
            end
            ST_PREFIX: begin
                o_cmd.pf_run = 1'b1;
                if (i_sts.pf_done) n_state = ST_PLACE;
            end
            ST_PLACE: begin
                o_cmd.pl_run = 1'b1;
                if (i_sts.pl_done) n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_last) n_state = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.out_run = 1'b1;
                if (i_sts.out_done) begin
                    o_cmd.set_clear = 1'b1;
                    n_state         = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: sv/csort_dp.sv
// Datapath: key buffer, histogram with read-modify-write, sorted buffer, output register.
`default_nettype none
`include "assert_macros.svh"

module csort_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire csort_pkg::t_cmd       i_cmd,
    input  wire logic                  i_in_valid,
    input  wire csort_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output csort_pkg::t_out_item       o_out_data,
    output csort_pkg::t_sts            o_sts
);

    localparam int KB = csort_pkg::KEY_BITS;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    // set bookkeeping
    logic [CW-1:0]          r_cnt;
    csort_pkg::t_slot       r_lo;
    csort_pkg::t_slot       r_hi;

    // placement read of the key buffer
    logic [AW-1:0]          r_pl_ptr;
    logic                   r_pl_more;
    logic                   r_k_v;

    // histogram read-modify-write stages
    logic                   r_a_v;
    logic                   r_a_dec;
    csort_pkg::t_slot       r_a_slot;
    logic [KB-1:0]          r_a_key;
    logic                   r_b_v;
    csort_pkg::t_slot       r_b_slot;
    logic [CW-1:0]          r_b_val;

    // prefix pass
    csort_pkg::t_slot       r_pf_ptr;
    logic                   r_pf_more;
    logic                   r_pf_v;
    csort_pkg::t_slot       r_pf_addr;
    logic [CW-1:0]          r_acc;

    // clearing sweep
    csort_pkg::t_slot       r_clr_ptr;
    csort_pkg::t_slot       r_clr_end;

    // output side
    logic [AW-1:0]          r_out_ptr;
    logic                   r_rd_pend;
    logic                   r_rd_last;
    logic                   r_ovalid;
    csort_pkg::t_out_item   r_odata;

    logic                   accept;
    logic                   keep;
    csort_pkg::t_slot       in_slot;
    logic [KB-1:0]          kram_rd;
    logic [KB-1:0]          srt_rd;
    logic [CW-1:0]          hist_rd;
    csort_pkg::t_slot       hist_raddr;
    csort_pkg::t_slot       hist_waddr;
    logic [CW-1:0]          hist_wdata;
    logic                   hist_we;
    logic                   pl_issue;
    logic                   pf_issue;
    logic                   out_issue;
    logic                   out_is_last;
    logic                   clr_last;
    logic [CW-1:0]          a_old;
    logic [CW-1:0]          a_new;
    logic [CW-1:0]          acc_new;

    assign accept   = i_cmd.load && i_in_valid;
    assign keep     = accept && (r_cnt != CW'(MAX_ITEMS));
    assign in_slot  = csort_pkg::slot_of(i_in_data.key);
    assign pl_issue = i_cmd.pl_run && r_pl_more;
    assign pf_issue = i_cmd.pf_run && r_pf_more;
    assign clr_last = i_cmd.clr_run && (r_clr_ptr == r_clr_end);

    assign out_issue   = i_cmd.out_run && !r_rd_pend && (!r_ovalid || i_out_ready);
    assign out_is_last = ((CW'(r_out_ptr) + CW'(1)) == r_cnt);

    // last write to this slot may not be visible in the registered read yet
    assign a_old   = (r_b_v && (r_b_slot == r_a_slot)) ? r_b_val : hist_rd;
    assign a_new   = r_a_dec ? (a_old - CW'(1)) : (a_old + CW'(1));
    assign acc_new = r_acc + hist_rd;

    assign hist_raddr = pf_issue ? r_pf_ptr :
                        r_k_v    ? csort_pkg::slot_of(kram_rd) : in_slot;

    always_comb begin
        hist_we    = 1'b1;
        hist_waddr = r_a_slot;
        hist_wdata = a_new;
        priority if (i_cmd.clr_run) begin
            hist_waddr = r_clr_ptr;
            hist_wdata = '0;
        end else if (r_pf_v) begin
            hist_waddr = r_pf_addr;
            hist_wdata = acc_new;
        end else begin
            hist_we = r_a_v;
        end
    end

    csort_ram #(.W(CW), .D(csort_pkg::KEY_RANGE)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rd)
    );

    csort_ram #(.W(KB), .D(MAX_ITEMS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (keep),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_in_data.key),
        .i_raddr (r_pl_ptr),
        .o_rdata (kram_rd)
    );

    csort_ram #(.W(KB), .D(MAX_ITEMS)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (r_a_v && r_a_dec),
        .i_waddr (a_new[AW-1:0]),
        .i_wdata (r_a_key),
        .i_raddr (r_out_ptr),
        .o_rdata (srt_rd)
    );

    // payload-only registers
    always_ff @(posedge i_clk) begin
        r_a_dec  <= r_k_v;
        r_a_slot <= hist_raddr;
        r_a_key  <= r_k_v ? kram_rd : i_in_data.key;
        r_b_slot <= r_a_slot;
        r_b_val  <= a_new;
        r_pf_addr <= r_pf_ptr;
        r_rd_last <= out_is_last;
        if (r_rd_pend) begin
            r_odata.sorted_key <= srt_rd;
            r_odata.last_res   <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_lo      <= '1;
            r_hi      <= '0;
            r_pl_ptr  <= '0;
            r_pl_more <= 1'b0;
            r_k_v     <= 1'b0;
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            r_pf_ptr  <= '0;
            r_pf_more <= 1'b0;
            r_pf_v    <= 1'b0;
            r_acc     <= '0;
            r_clr_ptr <= '0;
            r_clr_end <= '1;
            r_out_ptr <= '0;
            r_rd_pend <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_k_v     <= pl_issue;
            r_a_v     <= keep || r_k_v;
            r_b_v     <= r_a_v;
            r_pf_v    <= pf_issue;
            r_rd_pend <= out_issue;

            if (i_cmd.set_clear) begin
                r_cnt <= '0;
                r_lo  <= '1;
                r_hi  <= '0;
            end else if (keep) begin
                r_cnt <= r_cnt + CW'(1);
                if (in_slot < r_lo) r_lo <= in_slot;
                if (in_slot > r_hi) r_hi <= in_slot;
            end

            if (i_cmd.start) begin
                r_pl_ptr  <= AW'(r_cnt - CW'(1));
                r_pl_more <= 1'b1;
                r_pf_ptr  <= r_lo;
                r_pf_more <= 1'b1;
                r_acc     <= '0;
                r_clr_ptr <= r_lo;
                r_clr_end <= r_hi;
                r_out_ptr <= '0;
            end else begin
                if (pl_issue) begin
                    if (r_pl_ptr == '0) r_pl_more <= 1'b0;
                    else                r_pl_ptr  <= r_pl_ptr - AW'(1);
                end
                if (pf_issue) begin
                    if (r_pf_ptr == r_hi) r_pf_more <= 1'b0;
                    else                  r_pf_ptr  <= r_pf_ptr + csort_pkg::t_slot'(1);
                end
                if (r_pf_v) begin
                    r_acc <= acc_new;
                end
                if (i_cmd.clr_run && !clr_last) begin
                    r_clr_ptr <= r_clr_ptr + csort_pkg::t_slot'(1);
                end
                if (out_issue) begin
                    r_out_ptr <= r_out_ptr + AW'(1);
                end
            end

            if (r_rd_pend) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    assign o_sts.clr_last = clr_last;
    assign o_sts.pf_done  = !r_pf_more && !r_pf_v;
    assign o_sts.pl_done  = !r_pl_more && !r_k_v && !r_a_v;
    assign o_sts.out_done = out_issue && out_is_last;

    `ASSERT_CLK(a_hist_wr_onehot, i_clk, i_rst_n, $onehot0({i_cmd.clr_run, r_pf_v, r_a_v}),
                "histogram write sources overlap")
    `ASSERT_CLK(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_ITEMS),
                "item count above capacity")
    `ASSERT_IMPLY(a_out_slot_free, i_clk, i_rst_n, r_rd_pend, !r_ovalid,
                  "sorted read lands on a full output register")
    `ASSERT_IMPLY(a_range_order, i_clk, i_rst_n, r_cnt != '0, r_lo <= r_hi,
                  "min slot above max slot")
    `ASSERT_IMPLY(a_pf_gap, i_clk, i_rst_n, pf_issue, !r_a_v,
                  "prefix read overlaps histogram update")

endmodule

`default_nettype wire

FILE: sv/counting_sort.sv
// Top level of the counting sort: sequencer plus datapath.
//
//  Channel   Direction  Handshake                 Payload
//  in        sink       i_in_valid / o_in_ready   i_in_data  (key, last)
//  out       source     o_out_valid / i_out_ready o_out_data (sorted_key, last_res)
//
// Keys load one per cycle; the request that carries last ends the set.
// Sort of N keys spanning R histogram slots (max slot - min slot + 1):
// a prefix pass over R, placement over N, a clearing sweep over R, then
// output of each key with one sorted-buffer read in flight.
// After reset the 2^KEY_BITS-entry histogram is swept to zero, one entry a
// cycle, before the first request is taken.
// A stalled output holds the sort; no input is taken until the read of the
// last key of the run has been issued to the sorted buffer.
`default_nettype none

module counting_sort #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire csort_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output csort_pkg::t_out_item       o_out_data
);

    csort_pkg::t_cmd cmd;
    csort_pkg::t_sts sts;

    csort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    csort_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_sts       (sts)
    );

    assign o_in_ready = cmd.load;

endmodule

`default_nettype wire
